### hw/rtl/assert_macros.svh
// Assertion helpers for the RTL files; s3f_dpath includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property checked at every clock edge outside reset.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Property checked at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### hw/rtl/s3f_pkg.sv
package s3f_pkg;

  // Default sizes of the entry pool and the ghost ring.
  localparam int ENTRIES_DEF       = 256;
  localparam int GHOST_ENTRIES_DEF = 256;
  localparam int KEY_W             = 32;
  localparam int CAP_W             = 9;
  localparam int CFG_IDX_W         = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SMALL_CAP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAIN_CAP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GHOST_CAP = 2'd2;

  // Capacity values after reset.
  localparam logic [CAP_W-1:0] SMALL_CAP_RST = 9'd25;
  localparam logic [CAP_W-1:0] MAIN_CAP_RST  = 9'd230;
  localparam logic [CAP_W-1:0] GHOST_CAP_RST = 9'd230;

  localparam logic [1:0] FREQ_MAX = 2'd3;

  // Request operations.
  localparam logic OPER_PUT = 1'b0;
  localparam logic OPER_GET = 1'b1;

  // Outcome codes.
  localparam logic [1:0] OUT_HIT      = 2'd0;
  localparam logic [1:0] OUT_GHOST    = 2'd1;
  localparam logic [1:0] OUT_SMALL    = 2'd2;
  localparam logic [1:0] OUT_GET_MISS = 2'd3;

  typedef struct packed {
    logic             operation;
    logic [KEY_W-1:0] access_key;
  } in_req_t;

  typedef struct packed {
    logic [1:0]       outcome;
    logic             evicted_valid;
    logic [KEY_W-1:0] evicted_key;
    logic             evicted_to_ghost;
  } out_res_t;

  // One entry of the key pool.
  typedef struct packed {
    logic             valid;
    logic [1:0]       freq;
    logic [KEY_W-1:0] key;
  } ent_t;

  // Datapath commands issued by the controller.
  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_ACCEPT, OP_LOOK, OP_DECIDE, OP_GLOOK, OP_GSRD, OP_GSWR,
    OP_GDEC, OP_INSM, OP_INSS, OP_SPOP, OP_SEVAL, OP_GTRIM, OP_GPUSH, OP_CPOP,
    OP_CEVAL, OP_EMIT
  } dp_op_e;

  // Datapath status seen by the controller.
  typedef struct packed {
    logic clr_done;
    logic look_done;
    logic hit;
    logic is_get;
    logic free_ok;
    logic g_done;
    logic g_match;
    logic shift_more;
    logic main_over;
    logic small_over;
    logic freq_zero;
    logic out_free;
  } dp_stat_t;

endpackage

### hw/rtl/s3f_ctrl.sv
module s3f_ctrl import s3f_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_op_e   op_o
);

  typedef enum logic [21:0] {
    S_CLEAR  = 22'd1 << 0,
    S_IDLE   = 22'd1 << 1,
    S_LOOK   = 22'd1 << 2,
    S_DECIDE = 22'd1 << 3,
    S_GLOOK  = 22'd1 << 4,
    S_GSHCHK = 22'd1 << 5,
    S_GSRD   = 22'd1 << 6,
    S_GSWR   = 22'd1 << 7,
    S_GDEC   = 22'd1 << 8,
    S_INSM   = 22'd1 << 9,
    S_MCHK   = 22'd1 << 10,
    S_INSS   = 22'd1 << 11,
    S_SCHK   = 22'd1 << 12,
    S_SRD    = 22'd1 << 13,
    S_SPOP   = 22'd1 << 14,
    S_SEVAL  = 22'd1 << 15,
    S_GTRIM  = 22'd1 << 16,
    S_GPUSH  = 22'd1 << 17,
    S_CRD    = 22'd1 << 18,
    S_CPOP   = 22'd1 << 19,
    S_CEVAL  = 22'd1 << 20,
    S_DONE   = 22'd1 << 21
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Sequencing of one request through lookup, ghost search and queue updates.
  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    unique case (state_q)
      S_CLEAR: begin
        op_o = OP_CLEAR;
        if (stat_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_o    = OP_ACCEPT;
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        op_o = OP_LOOK;
        if (stat_i.look_done) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        op_o    = OP_DECIDE;
        state_d = (stat_i.hit || stat_i.is_get) ? S_DONE : S_GLOOK;
      end
      S_GLOOK: begin
        op_o = OP_GLOOK;
        if (stat_i.g_done) begin
          if (stat_i.g_match)      state_d = S_GSHCHK;
          else if (stat_i.free_ok) state_d = S_INSS;
          else                     state_d = S_DONE;
        end
      end
      S_GSHCHK: state_d = stat_i.shift_more ? S_GSRD : S_GDEC;
      S_GSRD:   state_d = S_GSWR;
      S_GSWR: begin
        op_o    = OP_GSWR;
        state_d = S_GSHCHK;
      end
      S_GDEC: begin
        op_o    = OP_GDEC;
        state_d = stat_i.free_ok ? S_INSM : S_DONE;
      end
      S_INSM: begin
        op_o    = OP_INSM;
        state_d = S_MCHK;
      end
      S_MCHK: state_d = stat_i.main_over ? S_CRD : S_DONE;
      S_INSS: begin
        op_o    = OP_INSS;
        state_d = S_SCHK;
      end
      S_SCHK: state_d = stat_i.small_over ? S_SRD : S_DONE;
      S_SRD:  state_d = S_SPOP;
      S_SPOP: begin
        op_o    = OP_SPOP;
        state_d = S_SEVAL;
      end
      S_SEVAL: begin
        op_o    = OP_SEVAL;
        state_d = stat_i.freq_zero ? S_GTRIM : S_MCHK;
      end
      S_GTRIM: begin
        op_o    = OP_GTRIM;
        state_d = S_GPUSH;
      end
      S_GPUSH: begin
        op_o    = OP_GPUSH;
        state_d = S_DONE;
      end
      S_CRD:  state_d = S_CPOP;
      S_CPOP: begin
        op_o    = OP_CPOP;
        state_d = S_CEVAL;
      end
      S_CEVAL: begin
        op_o    = OP_CEVAL;
        state_d = stat_i.freq_zero ? S_DONE : S_CRD;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          op_o    = OP_EMIT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
    if (state_q == S_GSRD) op_o = OP_GSRD;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hw/rtl/s3f_dpath.sv
`include "assert_macros.svh"

module s3f_dpath import s3f_pkg::*; #(
  parameter int ENTRIES       = ENTRIES_DEF,
  parameter int GHOST_ENTRIES = GHOST_ENTRIES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_op_e               op_i,
  output dp_stat_t             stat_o,
  input  in_req_t              in_req_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CAP_W-1:0]     cfg_data_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output out_res_t             out_res_o
);

  localparam int IW  = $clog2(ENTRIES);
  localparam int CW  = $clog2(ENTRIES + 1);
  localparam int GW  = $clog2(GHOST_ENTRIES);
  localparam int GCW = $clog2(GHOST_ENTRIES + 1);
  localparam int XW  = ((CW > CAP_W) ? CW : CAP_W) + 1;
  localparam int GXW = ((GCW > CAP_W) ? GCW : CAP_W) + 1;

  // Ring index helpers: head plus offset stays below twice the depth.
  function automatic logic [IW-1:0] wrap_e(input logic [IW-1:0] h, input logic [CW-1:0] a);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(a);
    if (s >= (CW+1)'(ENTRIES)) s = s - (CW+1)'(ENTRIES);
    return IW'(s);
  endfunction

  function automatic logic [GW-1:0] wrap_g(input logic [GW-1:0] h, input logic [GCW-1:0] a);
    logic [GCW:0] s;
    s = (GCW+1)'(h) + (GCW+1)'(a);
    if (s >= (GCW+1)'(GHOST_ENTRIES)) s = s - (GCW+1)'(GHOST_ENTRIES);
    return GW'(s);
  endfunction

  // Memories.
  ent_t              ent_mem   [ENTRIES];
  logic [IW-1:0]     sord_mem  [ENTRIES];
  logic [IW-1:0]     mord_mem  [ENTRIES];
  logic [KEY_W-1:0]  ghost_mem [GHOST_ENTRIES];
  ent_t              ent_rd_q;
  logic [IW-1:0]     sord_rd_q, mord_rd_q;
  logic [KEY_W-1:0]  ghost_rd_q;

  // Control registers.
  logic [CAP_W-1:0] scap_q, mcap_q, gcap_q;
  logic [IW-1:0]    clr_q;
  logic [CW-1:0]    scan_q, scnt_q, mcnt_q;
  logic [IW-1:0]    shead_q, mhead_q;
  logic [GCW-1:0]   gcnt_q, gi_q;
  logic [GW-1:0]    ghead_q;
  logic             pend_q, hit_q, free_q, gpend_q, gmatch_q, out_valid_q;

  // Payload registers.
  logic [KEY_W-1:0] key_q, ev_key_q;
  logic             oper_q, ev_valid_q, ev_ghost_q;
  logic [1:0]       outcome_q;
  logic [IW-1:0]    look_addr_q, hit_slot_q, free_slot_q, slot_q;
  logic [1:0]       hit_freq_q;
  logic [GCW-1:0]   gidx_q, gj_q;
  out_res_t         out_res_q;

  // Derived conditions.
  logic             freq_zero, look_hit, look_free, g_hit;
  logic [XW-1:0]    s_x, m_x;
  logic [GXW-1:0]   gcnt_x, glim;
  logic             gcap_nz;

  assign freq_zero = (ent_rd_q.freq == 2'd0);
  assign look_hit  = pend_q && ent_rd_q.valid && (ent_rd_q.key == key_q);
  assign look_free = pend_q && !ent_rd_q.valid && !free_q;
  assign g_hit     = gpend_q && !gmatch_q && (ghost_rd_q == key_q);
  assign s_x       = XW'(scnt_q);
  assign m_x       = XW'(mcnt_q);
  assign gcnt_x    = GXW'(gcnt_q);
  assign glim      = (GXW'(gcap_q) < GXW'(GHOST_ENTRIES)) ? GXW'(gcap_q) : GXW'(GHOST_ENTRIES);
  assign gcap_nz   = (gcap_q != '0);

  // Status toward the controller.
  always_comb begin
    stat_o.clr_done   = (clr_q == IW'(ENTRIES - 1));
    stat_o.look_done  = (scan_q == CW'(ENTRIES)) && !pend_q;
    stat_o.hit        = hit_q;
    stat_o.is_get     = (oper_q == OPER_GET);
    stat_o.free_ok    = free_q;
    stat_o.g_done     = (gi_q == gcnt_q) && !gpend_q;
    stat_o.g_match    = gmatch_q;
    stat_o.shift_more = ((GCW+1)'(gj_q) + (GCW+1)'(1)) < (GCW+1)'(gcnt_q);
    stat_o.main_over  = (m_x > XW'(mcap_q)) || ((s_x + m_x) > XW'(ENTRIES - 1));
    stat_o.small_over = (s_x > XW'(scap_q)) || ((s_x + m_x) > XW'(ENTRIES - 1));
    stat_o.freq_zero  = freq_zero;
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  // Entry memory port selection.
  logic          ent_we;
  logic [IW-1:0] ent_waddr, ent_raddr;
  ent_t          ent_wdata;

  always_comb begin
    ent_we    = 1'b0;
    ent_waddr = slot_q;
    ent_wdata = '0;
    unique case (op_i)
      OP_CLEAR: begin
        ent_we    = 1'b1;
        ent_waddr = clr_q;
      end
      OP_DECIDE: begin
        ent_we    = hit_q;
        ent_waddr = hit_slot_q;
        ent_wdata = '{valid: 1'b1,
                      freq: (hit_freq_q == FREQ_MAX) ? FREQ_MAX : hit_freq_q + 2'd1,
                      key: key_q};
      end
      OP_INSM, OP_INSS: begin
        ent_we    = 1'b1;
        ent_waddr = free_slot_q;
        ent_wdata = '{valid: 1'b1, freq: 2'd0, key: key_q};
      end
      OP_SEVAL: ent_we = freq_zero;
      OP_CEVAL: begin
        ent_we    = 1'b1;
        if (!freq_zero) ent_wdata = '{valid: 1'b1, freq: ent_rd_q.freq - 2'd1,
                                      key: ent_rd_q.key};
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (op_i)
      OP_SPOP: ent_raddr = sord_rd_q;
      OP_CPOP: ent_raddr = mord_rd_q;
      default: ent_raddr = scan_q[IW-1:0];
    endcase
  end

  // Order and ghost memory ports.
  logic          sord_we, mord_we, ghost_we;
  logic [IW-1:0] mord_wdata;
  logic [GW-1:0] ghost_waddr, ghost_raddr;
  logic [KEY_W-1:0] ghost_wdata;

  assign sord_we    = (op_i == OP_INSS);
  assign mord_we    = (op_i == OP_INSM) ||
                      (((op_i == OP_SEVAL) || (op_i == OP_CEVAL)) && !freq_zero);
  assign mord_wdata = (op_i == OP_INSM) ? free_slot_q : slot_q;

  always_comb begin
    ghost_we    = 1'b0;
    ghost_waddr = wrap_g(ghead_q, gj_q);
    ghost_wdata = ghost_rd_q;
    if (op_i == OP_GSWR) begin
      ghost_we = 1'b1;
    end else if (op_i == OP_GPUSH) begin
      ghost_we    = gcap_nz;
      ghost_waddr = wrap_g(ghead_q, gcnt_q);
      ghost_wdata = ev_key_q;
    end
    ghost_raddr = (op_i == OP_GSRD) ? wrap_g(ghead_q, gj_q + GCW'(1)) : wrap_g(ghead_q, gi_q);
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
    ent_rd_q <= ent_mem[ent_raddr];
    if (sord_we) sord_mem[wrap_e(shead_q, scnt_q)] <= free_slot_q;
    sord_rd_q <= sord_mem[shead_q];
    if (mord_we) mord_mem[wrap_e(mhead_q, mcnt_q)] <= mord_wdata;
    mord_rd_q <= mord_mem[mhead_q];
    if (ghost_we) ghost_mem[ghost_waddr] <= ghost_wdata;
    ghost_rd_q <= ghost_mem[ghost_raddr];
  end

  // Control state: pointers, counts, scan progress and capacities.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scap_q      <= SMALL_CAP_RST;
      mcap_q      <= MAIN_CAP_RST;
      gcap_q      <= GHOST_CAP_RST;
      clr_q       <= '0;
      scan_q      <= '0;
      scnt_q      <= '0;
      mcnt_q      <= '0;
      shead_q     <= '0;
      mhead_q     <= '0;
      gcnt_q      <= '0;
      ghead_q     <= '0;
      gi_q        <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      gpend_q     <= 1'b0;
      gmatch_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_SMALL_CAP: scap_q <= cfg_data_i;
          REG_MAIN_CAP:  mcap_q <= cfg_data_i;
          REG_GHOST_CAP: gcap_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (op_i == OP_EMIT) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      unique case (op_i)
        OP_CLEAR: clr_q <= clr_q + IW'(1);
        OP_ACCEPT: begin
          scan_q <= '0;
          pend_q <= 1'b0;
          hit_q  <= 1'b0;
          free_q <= 1'b0;
        end
        OP_LOOK: begin
          if (look_hit) hit_q <= 1'b1;
          if (look_free) free_q <= 1'b1;
          if (scan_q != CW'(ENTRIES)) begin
            pend_q <= 1'b1;
            scan_q <= scan_q + CW'(1);
          end else begin
            pend_q <= 1'b0;
          end
        end
        OP_DECIDE: begin
          gi_q     <= '0;
          gpend_q  <= 1'b0;
          gmatch_q <= 1'b0;
        end
        OP_GLOOK: begin
          if (g_hit) gmatch_q <= 1'b1;
          if (gi_q != gcnt_q) begin
            gpend_q <= 1'b1;
            gi_q    <= gi_q + GCW'(1);
          end else begin
            gpend_q <= 1'b0;
          end
        end
        OP_GDEC: gcnt_q <= gcnt_q - GCW'(1);
        OP_INSM: mcnt_q <= mcnt_q + CW'(1);
        OP_INSS: scnt_q <= scnt_q + CW'(1);
        OP_SPOP: begin
          shead_q <= wrap_e(shead_q, CW'(1));
          scnt_q  <= scnt_q - CW'(1);
        end
        OP_SEVAL: if (!freq_zero) mcnt_q <= mcnt_q + CW'(1);
        OP_GTRIM: begin
          // Drop the oldest keys so that one more fits under the limit.
          if (gcap_nz && (gcnt_x >= glim)) begin
            ghead_q <= wrap_g(ghead_q, GCW'(gcnt_x - glim + GXW'(1)));
            gcnt_q  <= GCW'(glim - GXW'(1));
          end
        end
        OP_GPUSH: if (gcap_nz) gcnt_q <= gcnt_q + GCW'(1);
        OP_CPOP: begin
          mhead_q <= wrap_e(mhead_q, CW'(1));
          mcnt_q  <= mcnt_q - CW'(1);
        end
        OP_CEVAL: if (!freq_zero) mcnt_q <= mcnt_q + CW'(1);
        default: ;
      endcase
    end
  end

  // Request payload and result fields.
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OP_ACCEPT: begin
        key_q      <= in_req_i.access_key;
        oper_q     <= in_req_i.operation;
        ev_valid_q <= 1'b0;
        ev_key_q   <= '0;
        ev_ghost_q <= 1'b0;
        outcome_q  <= OUT_SMALL;
      end
      OP_LOOK: begin
        look_addr_q <= scan_q[IW-1:0];
        if (look_hit) begin
          hit_slot_q <= look_addr_q;
          hit_freq_q <= ent_rd_q.freq;
        end
        if (look_free) free_slot_q <= look_addr_q;
      end
      OP_DECIDE: begin
        if (hit_q) outcome_q <= OUT_HIT;
        else if (oper_q == OPER_GET) outcome_q <= OUT_GET_MISS;
      end
      OP_GLOOK: begin
        gidx_q <= gi_q;
        if (g_hit) gj_q <= gidx_q;
      end
      OP_GSWR: gj_q <= gj_q + GCW'(1);
      OP_GDEC: outcome_q <= OUT_GHOST;
      OP_SPOP: slot_q <= sord_rd_q;
      OP_CPOP: slot_q <= mord_rd_q;
      OP_SEVAL: begin
        if (freq_zero) begin
          ev_valid_q <= 1'b1;
          ev_key_q   <= ent_rd_q.key;
          ev_ghost_q <= 1'b1;
        end
      end
      OP_CEVAL: begin
        if (freq_zero) begin
          ev_valid_q <= 1'b1;
          ev_key_q   <= ent_rd_q.key;
        end
      end
      OP_EMIT: out_res_q <= '{outcome: outcome_q, evicted_valid: ev_valid_q,
                              evicted_key: ev_key_q, evicted_to_ghost: ev_ghost_q};
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  `ASSERT_RST(a_pool_bound, clk_i, rst_ni, (s_x + m_x) <= XW'(ENTRIES), "pool overfilled")
  `ASSERT_RST(a_ghost_bound, clk_i, rst_ni, gcnt_q <= GCW'(GHOST_ENTRIES), "ghost overfilled")
  `ASSERT_RST(a_emit_free, clk_i, rst_ni, (op_i == OP_EMIT) |-> (!out_valid_q || out_ready_i), "result overwritten")
  `ASSERT_RST(a_ghost_flag, clk_i, rst_ni, (out_valid_q && out_res_q.evicted_to_ghost) |-> out_res_q.evicted_valid, "ghost flag without eviction")

endmodule

### hw/rtl/s3_fifo_replacement_policy_unit.sv
// One request at a time. The pool lookup scans every entry, followed by a decision step;
// a put miss adds a ghost search, a ghost hit compacts the ring one shifted key at a time,
// and a main overflow runs CLOCK steps over main. A hit or get miss goes from the decision
// straight to the result. The entry memory scan sets the rate: the next request is taken
// the cycle after the result is loaded, and never while one is still in flight.
// Reset: asynchronous, active low; then a clearing pass over the entry memory runs first.
module s3_fifo_replacement_policy_unit import s3f_pkg::*; #(
  parameter int ENTRIES       = ENTRIES_DEF,
  parameter int GHOST_ENTRIES = GHOST_ENTRIES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_req_t              in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_res_t             out_res_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CAP_W-1:0]     cfg_data_i
);

  dp_op_e   op;
  dp_stat_t stat;

  // Sequencer.
  s3f_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .op_o       (op)
  );

  // Memories, queue pointers and result register.
  s3f_dpath #(
    .ENTRIES       (ENTRIES),
    .GHOST_ENTRIES (GHOST_ENTRIES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .stat_o      (stat),
    .in_req_i    (in_req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_res_o   (out_res_o)
  );

endmodule
